### rtl/core/rfhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfhp_pkg;

    localparam int FIELD_COUNT_DEF = 4;
    localparam int FIELD_NUM_W     = 3;
    localparam int VALUE_W         = 16;
    localparam int PROD_W          = VALUE_W + 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    typedef enum logic [1:0] {
        PH_FIELDS  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    // one character beat held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] char_in;
        logic       end_of_string;
    } char_beat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // tab, newline, vertical tab, form feed, carriage return, space
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            t = c - CH_ZERO;
        end
        else if ((c >= CH_UA) && (c <= CH_UF))
        begin
            t = c - CH_UA + 8'd10;
        end
        else if ((c >= CH_LA) && (c <= CH_LF))
        begin
            t = c - CH_LA + 8'd10;
        end
        return t[3:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/rfhp_char_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rfhp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_string;

    modport source (output valid, output char_in, output end_of_string, input ready);
    modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

`default_nettype wire

### rtl/core/rfhp_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rfhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/rfhp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rfhp_in_stage
    import rfhp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rfhp_char_if.sink   in_ch,
    input  wire logic   advance,
    output char_beat_t  beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       eos_reg;
    logic       take;

    // register frees up when the parser consumes the held beat
    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= in_ch.char_in;
            eos_reg  <= in_ch.end_of_string;
        end
    end

    assign beat.valid         = valid_reg;
    assign beat.char_in       = char_reg;
    assign beat.end_of_string = eos_reg;

endmodule

`default_nettype wire

### rtl/core/rfhp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module rfhp_parser
    import rfhp_pkg::*;
#(
    parameter int FIELD_COUNT = FIELD_COUNT_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  char_beat_t  beat,
    output logic        advance,
    rfhp_byte_if.source out_ch
);

    localparam logic [FIELD_NUM_W:0] FC = (FIELD_NUM_W + 1)'(FIELD_COUNT);

    phase_t                 phase_reg, phase_next;
    logic [FIELD_NUM_W-1:0] fnum_reg, fnum_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic                   neg_reg, neg_next;
    logic                   seen_reg, seen_next;
    logic                   stop_reg, stop_next;
    logic [VALUE_W-1:0]     left_reg, left_next;
    logic [3:0]             hi_reg, hi_next;
    logic                   pend_reg, pend_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;

    logic                   fire;
    logic                   res_valid;
    logic [7:0]             res_byte;
    logic                   res_last;
    logic [7:0]             c;
    logic [3:0]             hex_d;
    logic [PROD_W-1:0]      prod;
    logic [VALUE_W-1:0]     len;

    assign advance = !out_valid_reg || out_ch.ready;
    assign fire    = beat.valid && advance;
    assign c       = beat.char_in;
    assign hex_d   = hex_value(c);

    // value * 10 + digit, saturating
    assign prod = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1)
                + {{(PROD_W - 4){1'b0}}, c[3:0]};
    assign len  = neg_reg ? '0 : value_reg;

    always_comb
    begin
        phase_next = phase_reg;
        fnum_next  = fnum_reg;
        value_next = value_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        stop_next  = stop_reg;
        left_next  = left_reg;
        hi_next    = hi_reg;
        pend_next  = pend_reg;
        res_valid  = 1'b0;
        res_byte   = {hi_reg, hex_d};
        res_last   = 1'b0;
        if (beat.end_of_string)
        begin
            phase_next = PH_FIELDS;
            fnum_next  = '0;
            value_next = '0;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            stop_next  = 1'b0;
            left_next  = '0;
            hi_next    = '0;
            pend_next  = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_FIELDS:
                begin
                    if (c == CH_COMMA)
                    begin
                        if (({1'b0, fnum_reg} + 1'b1) >= FC)
                        begin
                            left_next  = len;
                            phase_next = (len != '0) ? PH_PAYLOAD : PH_DONE;
                            hi_next    = '0;
                            pend_next  = 1'b0;
                        end
                        else
                        begin
                            fnum_next = fnum_reg + 1'b1;
                        end
                        value_next = '0;
                        neg_next   = 1'b0;
                        seen_next  = 1'b0;
                        stop_next  = 1'b0;
                    end
                    else if (!stop_reg)
                    begin
                        if (is_digit(c))
                        begin
                            value_next = (prod > PROD_W'(VALUE_MAX)) ? VALUE_MAX
                                                                     : prod[VALUE_W-1:0];
                            seen_next  = 1'b1;
                        end
                        else if (((c == CH_PLUS) || (c == CH_MINUS)) && !seen_reg)
                        begin
                            seen_next = 1'b1;
                            if (c == CH_MINUS)
                            begin
                                neg_next = 1'b1;
                            end
                        end
                        else if (!(is_blank(c) && !seen_reg))
                        begin
                            stop_next = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (!pend_reg)
                    begin
                        hi_next   = hex_d;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        left_next = left_reg - 1'b1;
                        hi_next   = '0;
                        res_valid = 1'b1;
                        res_last  = (left_reg == VALUE_W'(1));
                        if (res_last)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid_next = advance ? (fire && res_valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIELDS;
            fnum_reg      <= '0;
            value_reg     <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            stop_reg      <= 1'b0;
            left_reg      <= '0;
            hi_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                fnum_reg  <= fnum_next;
                value_reg <= value_next;
                neg_reg   <= neg_next;
                seen_reg  <= seen_next;
                stop_reg  <= stop_next;
                left_reg  <= left_next;
                hi_reg    <= hi_next;
                pend_reg  <= pend_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.payload_byte = out_byte_reg;
    assign out_ch.last_byte    = out_last_reg;

    a_last_ends_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res_last) |=> (phase_reg == PH_DONE))
        else $error("last byte did not end the payload phase");

    a_pend_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (phase_reg == PH_PAYLOAD))
        else $error("high nibble pending outside payload phase");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (left_reg != '0))
        else $error("payload phase with no bytes left");

    a_field_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FIELDS) |-> ({1'b0, fnum_reg} < FC))
        else $error("field counter ran past the length field");

endmodule

`default_nettype wire

### rtl/core/response_field_hex_payload_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// output: a low digit passes the input register; the parser then registers its payload byte
// throughput: one character per cycle while the output is not stalled
// a waiting result stalls the parser; the input register then holds at most one beat
// reset: asynchronous active-low, returns to field phase with all counters cleared

module response_field_hex_payload_parser
    import rfhp_pkg::*;
#(
    parameter int FIELD_COUNT = FIELD_COUNT_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rfhp_char_if.sink   in_ch,
    rfhp_byte_if.source out_ch
);

    char_beat_t beat;
    logic       advance;

    rfhp_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (advance),
        .beat    (beat)
    );

    rfhp_parser #(
        .FIELD_COUNT (FIELD_COUNT)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .advance (advance),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire
